>>> hdl/ljp_pkg.sv
// Shared types, register codes and helpers for the lossless JPEG predictor row core.
package ljp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PREC_W       = 5;
  localparam int SEL_W        = 3;
  localparam int LWIDTH_W     = 13;
  localparam int COMP_W       = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [SAMPLE_W-1:0] diff_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRECISION        = 2'd0,
    REG_PREDICTOR_SELECT = 2'd1,
    REG_LINE_WIDTH       = 2'd2,
    REG_COMPONENTS       = 2'd3
  } cfg_reg_t;

  // Lossless predictor numbers
  typedef enum logic [SEL_W-1:0] {
    PRED_NONE      = 3'd0,
    PRED_LEFT      = 3'd1,
    PRED_UP        = 3'd2,
    PRED_UPLEFT    = 3'd3,
    PRED_PLANE     = 3'd4,
    PRED_LEFT_GRAD = 3'd5,
    PRED_UP_GRAD   = 3'd6,
    PRED_AVERAGE   = 3'd7
  } pred_sel_t;

  localparam logic [PREC_W-1:0]   PRECISION_RESET = 5'd16;
  localparam logic [SEL_W-1:0]    SELECT_RESET    = 3'd1;
  localparam logic [LWIDTH_W-1:0] LWIDTH_RESET    = 13'd4096;
  localparam logic [COMP_W-1:0]   COMP_RESET      = 3'd1;
  localparam sample_t             COLPRED_RESET   = 16'h8000;

  // Position flags handed from the position tracker to the sample datapath
  typedef struct packed {
    logic col0;
    logic first_row;
    logic start_frame;
    logic row_end;
  } pos_t;

  function automatic sample_t half_range(input logic [PREC_W-1:0] prec);
    logic [SAMPLE_W:0] one_hot;
    one_hot = '0;
    if (prec == '0 || prec > 5'd16) begin
      return '0;
    end
    one_hot = (SAMPLE_W+1)'(1) << (prec - 5'd1);
    return one_hot[SAMPLE_W-1:0];
  endfunction

endpackage

>>> hdl/ljp_if.sv
// Handshake channel interfaces: difference input, sample output, configuration write.
interface ljp_diff_if;
  logic                 valid;
  logic                 ready;
  ljp_pkg::diff_t       difference;
  logic                 start_frame;
  modport source (output valid, difference, start_frame, input ready);
  modport sink   (input valid, difference, start_frame, output ready);
endinterface

interface ljp_sample_if;
  logic                 valid;
  logic                 ready;
  ljp_pkg::sample_t     sample;
  logic                 data_error;
  logic                 row_end;
  modport source (output valid, sample, data_error, row_end, input ready);
  modport sink   (input valid, sample, data_error, row_end, output ready);
endinterface

interface ljp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ljp_pkg::CFG_INDEX_W-1:0]   index;
  logic [ljp_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/ljp_line_mem.sv
// One-line sample store with registered read and write-to-read bypass.
module ljp_line_mem #(
  parameter int ADDR_W = 14
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  ljp_pkg::sample_t         wr_data,
  output ljp_pkg::sample_t         rd_data
);
  import ljp_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  sample_t mem [DEPTH];
  sample_t rd_q;
  sample_t byp_data;
  logic    byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A write landing on the address being read supplies the fresh value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

>>> hdl/ljp_position.sv
// Column, component and first-row tracking plus line store address generation.
module ljp_position #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_COMPONENTS = 4,
  parameter int COL_W          = 12,
  parameter int CW             = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           start_frame,
  input  logic [ljp_pkg::LWIDTH_W-1:0]   line_width,
  input  logic [ljp_pkg::COMP_W-1:0]     components,
  output logic [COL_W-1:0]               col_sel,
  output logic [CW-1:0]                  comp_sel,
  output ljp_pkg::pos_t                  pos
);
  import ljp_pkg::*;

  logic [COL_W-1:0]  col;
  logic [CW-1:0]     comp;
  logic              first_row;

  logic [16:0]       lw_ext;
  logic [16:0]       w_eff;
  logic [COL_W-1:0]  wm1;
  logic [COMP_W-1:0] n_eff;
  logic [CW-1:0]     nm1;
  logic [COL_W-1:0]  col_eff;
  logic [CW-1:0]     comp_eff;
  logic              fr_eff;
  logic              last_comp;
  logic              last_col;

  always_comb begin
    lw_ext = 17'(line_width);
    if (line_width == '0) begin
      w_eff = 17'd1;
    end else if (lw_ext > 17'(MAX_WIDTH)) begin
      w_eff = 17'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    wm1 = COL_W'(w_eff - 17'd1);

    if (components == '0) begin
      n_eff = 3'd1;
    end else if (components > COMP_W'(MAX_COMPONENTS)) begin
      n_eff = COMP_W'(MAX_COMPONENTS);
    end else begin
      n_eff = components;
    end
    nm1 = CW'(n_eff - 3'd1);

    // A new frame restarts the position before this item is placed
    col_eff  = start_frame ? '0 : col;
    comp_eff = start_frame ? '0 : comp;
    fr_eff   = start_frame ? 1'b1 : first_row;

    col_sel  = (col_eff > wm1) ? wm1 : col_eff;
    comp_sel = (comp_eff > nm1) ? nm1 : comp_eff;

    last_comp = (comp_sel == nm1);
    last_col  = (col_sel == wm1);

    pos.col0        = (col_sel == '0);
    pos.first_row   = fr_eff;
    pos.start_frame = start_frame;
    pos.row_end     = last_comp && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      comp      <= '0;
      first_row <= 1'b1;
    end else if (advance) begin
      if (last_comp) begin
        comp <= '0;
        if (last_col) begin
          col       <= '0;
          first_row <= 1'b0;
        end else begin
          col       <= col_sel + COL_W'(1);
          first_row <= fr_eff;
        end
      end else begin
        comp      <= comp_sel + CW'(1);
        col       <= col_sel;
        first_row <= fr_eff;
      end
    end
  end

endmodule

>>> hdl/ljp_predict.sv
// Predictor selection and sample reconstruction with precision check.
module ljp_predict (
  input  ljp_pkg::sample_t                left,
  input  ljp_pkg::sample_t                up,
  input  ljp_pkg::sample_t                upper_left,
  input  ljp_pkg::sample_t                col_pred,
  input  logic                            col0,
  input  logic                            first_row,
  input  logic [ljp_pkg::SEL_W-1:0]       predictor_select,
  input  logic [ljp_pkg::PREC_W-1:0]      precision,
  input  ljp_pkg::diff_t                  difference,
  output ljp_pkg::sample_t                sample,
  output logic                            data_error
);
  import ljp_pkg::*;

  logic signed [17:0] s_l;
  logic signed [17:0] s_u;
  logic signed [17:0] s_ul;
  logic signed [17:0] grad_u;
  logic signed [17:0] grad_l;
  logic signed [17:0] pred;
  logic signed [17:0] sum;

  always_comb begin
    s_l    = 18'(left);
    s_u    = 18'(up);
    s_ul   = 18'(upper_left);
    grad_u = s_u - s_ul;
    grad_l = s_l - s_ul;

    if (col0) begin
      pred = 18'(col_pred);
    end else if (first_row) begin
      pred = s_l;
    end else begin
      unique case (pred_sel_t'(predictor_select))
        PRED_NONE:      pred = '0;
        PRED_LEFT:      pred = s_l;
        PRED_UP:        pred = s_u;
        PRED_UPLEFT:    pred = s_ul;
        PRED_PLANE:     pred = s_l + s_u - s_ul;
        PRED_LEFT_GRAD: pred = s_l + (grad_u >>> 1);
        PRED_UP_GRAD:   pred = s_u + (grad_l >>> 1);
        PRED_AVERAGE:   pred = (s_l + s_u) >>> 1;
      endcase
    end

    sum        = pred + 18'(difference);
    sample     = sum[SAMPLE_W-1:0];
    data_error = (precision < 5'd16) && ((sample >> precision) != '0);
  end

endmodule

>>> hdl/lossless_jpeg_predictor_row_core.sv
// Top level of the lossless JPEG predictor row core.
//
// Use: decoded signed differences enter on the diffs channel, one per sample,
// in raster order with components interleaved inside each pixel. start_frame on
// an item restarts the position and the column predictors before that item.
// Each item yields exactly one item on the pixels channel: the rebuilt sample,
// a precision error flag and a row_end flag on the last sample of a row.
// Configuration (precision, predictor_select, line_width, components) is
// written through the cfg channel, index = register number; cfg is always ready.
// It must be written only while the core is idle; the core does not check.
// Throughput: one item per cycle while pixels.ready is high. The line store read
// is issued on acceptance and registered; the predictor and adder sit between
// that input stage and the output register. Left and column neighbors come from
// the result of the previous item of the same component, written as it moves
// into the output register.
// Reset: configuration returns to 16 bits, predictor 1, width 4096, one
// component; position goes to the first row, column predictors to half range.
// The line store is not cleared: the first row never uses the upper line.
// Stall: while pixels.ready is low the output holds, the input stage holds,
// and diffs.ready drops once the input stage is occupied.
module lossless_jpeg_predictor_row_core #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  ljp_diff_if.sink             diffs,
  ljp_sample_if.source         pixels,
  ljp_cfg_if.sink              cfg
);
  import ljp_pkg::*;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int ADDR_W = COL_W + CW;

  // Configuration registers
  logic [PREC_W-1:0]   precision;
  logic [SEL_W-1:0]    predictor_select;
  logic [LWIDTH_W-1:0] line_width;
  logic [COMP_W-1:0]   components;

  // Input stage
  logic                s1_valid;
  diff_t               s1_diff;
  pos_t                s1_pos;
  logic [CW-1:0]       s1_c;
  logic [ADDR_W-1:0]   s1_addr;

  // Per-component neighbor state
  sample_t             left_samples [MAX_COMPONENTS];
  sample_t             upper_left_samples [MAX_COMPONENTS];
  sample_t             column_predictors [MAX_COMPONENTS];

  logic                acc;
  logic                s1_adv;
  logic [COL_W-1:0]    col_sel;
  logic [CW-1:0]       comp_sel;
  pos_t                pos;
  sample_t             up;
  sample_t             half;
  sample_t             col_pred;
  sample_t             sample_comb;
  logic                err_comb;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision        <= PRECISION_RESET;
      predictor_select <= SELECT_RESET;
      line_width       <= LWIDTH_RESET;
      components       <= COMP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_PRECISION:        precision        <= cfg.data[PREC_W-1:0];
        REG_PREDICTOR_SELECT: predictor_select <= cfg.data[SEL_W-1:0];
        REG_LINE_WIDTH:       line_width       <= cfg.data[LWIDTH_W-1:0];
        REG_COMPONENTS:       components       <= cfg.data[COMP_W-1:0];
      endcase
    end
  end

  // Advance the input stage when the output register is free or being taken
  assign s1_adv      = s1_valid && (!pixels.valid || pixels.ready);
  assign diffs.ready = !s1_valid || s1_adv;
  assign acc         = diffs.valid && diffs.ready;

  ljp_position #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .COL_W          (COL_W),
    .CW             (CW)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .advance     (acc),
    .start_frame (diffs.start_frame),
    .line_width  (line_width),
    .components  (components),
    .col_sel     (col_sel),
    .comp_sel    (comp_sel),
    .pos         (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_diff <= diffs.difference;
      s1_pos  <= pos;
      s1_c    <= comp_sel;
      s1_addr <= {col_sel, comp_sel};
    end
  end

  // Read the upper neighbor on acceptance; write the result as it leaves
  ljp_line_mem #(
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr ({col_sel, comp_sel}),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (sample_comb),
    .rd_data (up)
  );

  // A frame start sees half range in every column predictor
  assign half     = half_range(precision);
  assign col_pred = s1_pos.start_frame ? half : column_predictors[s1_c];

  ljp_predict u_predict (
    .left             (left_samples[s1_c]),
    .up               (up),
    .upper_left       (upper_left_samples[s1_c]),
    .col_pred         (col_pred),
    .col0             (s1_pos.col0),
    .first_row        (s1_pos.first_row),
    .predictor_select (predictor_select),
    .precision        (precision),
    .difference       (s1_diff),
    .sample           (sample_comb),
    .data_error       (err_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        left_samples[i]       <= '0;
        upper_left_samples[i] <= '0;
        column_predictors[i]  <= COLPRED_RESET;
      end
    end else if (s1_adv) begin
      left_samples[s1_c]       <= sample_comb;
      upper_left_samples[s1_c] <= up;
      // The first column advances its own predictor; a frame start resets the rest
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        if (s1_pos.col0 && (s1_c == CW'(i))) begin
          column_predictors[i] <= sample_comb;
        end else if (s1_pos.start_frame) begin
          column_predictors[i] <= half;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (s1_adv) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixels.sample     <= sample_comb;
      pixels.data_error <= err_comb;
      pixels.row_end    <= s1_pos.row_end;
    end
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_addr)))
    else $error("input stage lost or changed a stalled item");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("accepted item did not reach the input stage");

  a_frame_start_pos: assert property (@(posedge clk) disable iff (rst)
    (acc && diffs.start_frame) |=> (s1_pos.first_row && s1_pos.col0))
    else $error("frame start not placed at first row, first column");

  a_error_precision: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && err_comb) |-> (precision < 5'd16))
    else $error("precision error flagged at full precision");

endmodule
